// ----- rtl/sfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

	localparam int unsigned PAYLOAD_LEN = 24;
	localparam int unsigned TEXT_LEN    = 13;
	localparam int unsigned CNT_W       = $clog2(PAYLOAD_LEN + 1);
	localparam int unsigned IDX_W       = $clog2(TEXT_LEN);

	localparam logic [7:0] HDR1_BYTE   = 8'h83;
	localparam logic [7:0] HDR2_BYTE   = 8'h45;
	localparam logic [7:0] LEN_BYTE    = 8'h18;
	localparam logic [7:0] POWER_MASK  = 8'h01;
	localparam logic [7:0] MUTE_MASK   = 8'h08;
	localparam logic [7:0] AUDIO_MASK  = 8'h0F;
	localparam logic [7:0] VIDEO_MASK  = 8'hF0;
	localparam logic [8:0] VOL_OFFSET  = 9'd76;
	localparam logic [8:0] VOL_IDLE    = 9'h1B4;   // -76
	localparam logic [15:0] TIMEOUT_RST = 16'd100;

	// payload byte positions
	localparam logic [CNT_W-1:0] POS_FLAGS  = CNT_W'(13);
	localparam logic [CNT_W-1:0] POS_INPUTS = CNT_W'(14);
	localparam logic [CNT_W-1:0] POS_VOLUME = CNT_W'(16);
	localparam logic [CNT_W-1:0] POS_SUM    = CNT_W'(PAYLOAD_LEN);
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(TEXT_LEN - 1);

	localparam logic IN_BYTE = 1'b0;
	localparam logic IN_TICK = 1'b1;

	typedef enum logic [1:0] {
		RK_IDLE   = 2'd0,
		RK_STATUS = 2'd1,
		RK_TEXT   = 2'd2
	} report_kind_t;

	typedef enum logic [3:0] {
		PH_HDR1    = 4'b0001,
		PH_HDR2    = 4'b0010,
		PH_LEN     = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_STAT = 4'b0100,
		ST_TEXT = 4'b1000
	} seq_t;

endpackage

`default_nettype wire

// ----- rtl/status_frame_receiver.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Accept               Contents
// s_*       in   s_tvalid & s_tready  tuser: kind; tdata: rx_byte
// m_*       out  m_tvalid & m_tready  tuser: report_kind; tlast: last; tdata: report
// cfg_*     in   cfg_we               payload_timeout_ticks
//
// The checksum byte of a good frame with power set starts a walk of the shared
// byte comparator over the text and display stores, then the 14 report words
// load one per cycle while the output register is free.
// Reset is asynchronous, active low; all stores of text are unwritten after it.
// s_tready is low from that checksum word until the last report word is loaded
// and while a report waits with m_tready low.

module status_frame_receiver
	import sfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tuser,   // [0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] power, [1] mute, [10:2] volume, [14:11] audio_input, [18:15] video_input,
	// [23:19] changed_flags, [31:24] text_char, [35:32] text_index, [39:36] zero
	output logic [39:0]      m_tdata,
	output logic [1:0]       m_tuser,   // [1:0] report_kind
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	logic [15:0]      timeout_q;
	phase_t           phase_q;
	seq_t             seq_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       sum_q;
	logic [15:0]      ticks_q;
	logic [7:0]       text_q [TEXT_LEN];
	logic [7:0]       disp_q [TEXT_LEN];
	logic [7:0]       flags_q;
	logic [7:0]       inputs_q;
	logic [7:0]       volb_q;
	logic             power_seen_q;
	logic             mute_seen_q;
	logic [8:0]       vol_seen_q;
	logic [7:0]       inputs_seen_q;
	logic             disp_valid_q;
	logic             diff_q;
	logic [IDX_W-1:0] idx_q;

	logic             out_valid_q;
	report_kind_t     out_kind_q;
	logic             out_power_q;
	logic             out_mute_q;
	logic [8:0]       out_vol_q;
	logic [7:0]       out_inputs_q;
	logic [4:0]       out_chg_q;
	logic [7:0]       out_char_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_last_q;

	logic             out_free;
	logic             out_load;
	logic             in_acc;
	logic             do_idle;
	logic             start_walk;
	logic [8:0]       vol_now;
	logic             mute_now;
	logic             on_now;
	logic [4:0]       chg;
	logic             char_ne;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (seq_q == ST_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = do_idle || (out_free && (seq_q == ST_STAT || seq_q == ST_TEXT));

	assign vol_now  = {1'b0, volb_q} - VOL_OFFSET;
	assign mute_now = |(flags_q & MUTE_MASK);
	assign on_now   = !power_seen_q;
	assign char_ne  = text_q[idx_q] != disp_q[idx_q];

	always_comb begin
		chg    = '0;
		chg[0] = on_now;
		chg[1] = on_now || (mute_seen_q != mute_now);
		chg[2] = on_now || (vol_seen_q != vol_now);
		chg[3] = on_now || (inputs_seen_q != inputs_q);
		chg[4] = on_now || !disp_valid_q || diff_q;
	end

	// decode of one accepted word
	always_comb begin
		do_idle    = 1'b0;
		start_walk = 1'b0;
		if (in_acc) begin
			if (s_tuser == IN_TICK) begin
				do_idle = (phase_q == PH_PAYLOAD) && (ticks_q >= timeout_q);
			end else begin
				unique case (phase_q)
					PH_HDR1: ;
					PH_HDR2: do_idle = s_tdata != HDR2_BYTE;
					PH_LEN:  do_idle = s_tdata != LEN_BYTE;
					PH_PAYLOAD: begin
						if (count_q == POS_SUM) begin
							if (sum_q != s_tdata || !(|(flags_q & POWER_MASK)))
								do_idle = 1'b1;
							else
								start_walk = 1'b1;
						end
					end
					default: do_idle = 1'b1;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= TIMEOUT_RST;
			phase_q       <= PH_HDR1;
			seq_q         <= ST_IDLE;
			count_q       <= '0;
			sum_q         <= '0;
			ticks_q       <= '0;
			power_seen_q  <= 1'b0;
			mute_seen_q   <= 1'b0;
			vol_seen_q    <= VOL_IDLE;
			inputs_seen_q <= '0;
			disp_valid_q  <= 1'b0;
			diff_q        <= 1'b0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we)
				timeout_q <= cfg_wdata;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			if (in_acc && s_tuser == IN_TICK) begin
				if (phase_q == PH_PAYLOAD && !do_idle)
					ticks_q <= ticks_q + 16'd1;
			end else if (in_acc) begin
				unique case (phase_q)
					PH_HDR1: begin
						if (s_tdata == HDR1_BYTE)
							phase_q <= PH_HDR2;
					end
					PH_HDR2: begin
						if (!do_idle)
							phase_q <= PH_LEN;
					end
					PH_LEN: begin
						if (!do_idle) begin
							phase_q <= PH_PAYLOAD;
							count_q <= '0;
							sum_q   <= '0;
							ticks_q <= '0;
						end
					end
					PH_PAYLOAD: begin
						if (count_q != POS_SUM) begin
							sum_q   <= sum_q + s_tdata;
							count_q <= count_q + CNT_W'(1);
						end else if (!do_idle) begin
							phase_q <= PH_HDR1;
						end
					end
					// unknown phase goes back to hunting through the idle report
					default: ;
				endcase
			end

			if (do_idle) begin
				phase_q       <= PH_HDR1;
				power_seen_q  <= 1'b0;
				mute_seen_q   <= 1'b0;
				vol_seen_q    <= VOL_IDLE;
				inputs_seen_q <= '0;
				disp_valid_q  <= 1'b0;
			end

			if (start_walk) begin
				seq_q  <= ST_CMP;
				idx_q  <= '0;
				diff_q <= 1'b0;
			end

			unique case (seq_q)
				ST_IDLE: ;
				ST_CMP: begin
					diff_q <= diff_q || char_ne;
					if (idx_q == IDX_LAST) begin
						idx_q <= '0;
						seq_q <= ST_STAT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_STAT: begin
					if (out_free) begin
						power_seen_q  <= 1'b1;
						mute_seen_q   <= mute_now;
						vol_seen_q    <= vol_now;
						inputs_seen_q <= inputs_q;
						disp_valid_q  <= 1'b1;
						seq_q         <= ST_TEXT;
					end
				end
				ST_TEXT: begin
					if (out_free) begin
						if (idx_q == IDX_LAST) begin
							idx_q <= '0;
							seq_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: seq_q <= ST_IDLE;
			endcase
		end
	end

	// payload storage and report words; no reset needed
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == IN_BYTE && phase_q == PH_PAYLOAD) begin
			if (count_q < CNT_W'(TEXT_LEN))
				text_q[count_q[IDX_W-1:0]] <= s_tdata;
			if (count_q == POS_FLAGS)
				flags_q <= s_tdata;
			if (count_q == POS_INPUTS)
				inputs_q <= s_tdata;
			if (count_q == POS_VOLUME)
				volb_q <= s_tdata;
		end

		// old character is compared in the same cycle it is overwritten
		if (seq_q == ST_CMP)
			disp_q[idx_q] <= text_q[idx_q];

		if (do_idle) begin
			out_kind_q   <= RK_IDLE;
			out_power_q  <= 1'b0;
			out_mute_q   <= 1'b0;
			out_vol_q    <= VOL_IDLE;
			out_inputs_q <= '0;
			out_chg_q    <= '0;
			out_char_q   <= '0;
			out_idx_q    <= '0;
			out_last_q   <= 1'b1;
		end else if (seq_q == ST_STAT && out_free) begin
			out_kind_q   <= RK_STATUS;
			out_power_q  <= 1'b1;
			out_mute_q   <= mute_now;
			out_vol_q    <= vol_now;
			out_inputs_q <= inputs_q;
			out_chg_q    <= chg;
			out_char_q   <= '0;
			out_idx_q    <= '0;
			out_last_q   <= 1'b0;
		end else if (seq_q == ST_TEXT && out_free) begin
			out_kind_q   <= RK_TEXT;
			out_power_q  <= 1'b0;
			out_mute_q   <= 1'b0;
			out_vol_q    <= '0;
			out_inputs_q <= '0;
			out_chg_q    <= '0;
			out_char_q   <= text_q[idx_q];
			out_idx_q    <= idx_q;
			out_last_q   <= idx_q == IDX_LAST;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0000, out_idx_q, out_char_q, out_chg_q,
		4'((out_inputs_q & VIDEO_MASK) >> 4), 4'(out_inputs_q & AUDIO_MASK),
		out_vol_q, out_mute_q, out_power_q};

endmodule

`default_nettype wire
